### rtl/gamepad_keystroke_synthesizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gamepad keystroke synthesizer
// Shared macros for clocked checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_KEYSTROKE_SYNTHESIZER_ASSERT_SVH
`define GAMEPAD_KEYSTROKE_SYNTHESIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GKS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GKS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/gks_pkg.sv
// ----------------------------------------------------------------------------
// gks_pkg
// Types, register indexes, reset values and event codes of the keystroke
// synthesizer.
// ----------------------------------------------------------------------------
package gks_pkg;

	// Default size of the key mask.
	localparam int KEY_COUNT_DEF = 34;

	// Fixed layout of the key mask.
	localparam int BUTTON_COUNT    = 16;
	localparam int LEFT_TRIG_BIT   = 16;
	localparam int RIGHT_TRIG_BIT  = 17;
	localparam int LEFT_STICK_LSB  = 18;
	localparam int RIGHT_STICK_LSB = 26;
	localparam int STICK_DIRS      = 8;
	localparam int MASK_MAX        = 64;
	localparam int GUIDE_BIT       = 10;
	localparam int UNKNOWN_BIT     = 11;

	// Configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_PERIOD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIG_THRESH   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STICK_THRESH  = 3'd3;

	localparam logic [15:0] RESET_REPEAT_DELAY  = 16'd400;
	localparam logic [15:0] RESET_REPEAT_PERIOD = 16'd100;
	localparam logic [7:0]  RESET_TRIG_THRESH   = 8'd31;
	localparam logic [14:0] RESET_STICK_THRESH  = 15'd19968;

	// Event kinds.
	localparam logic [1:0] KIND_DOWN   = 2'd0;
	localparam logic [1:0] KIND_UP     = 2'd1;
	localparam logic [1:0] KIND_REPEAT = 2'd2;

	// Typematic repeat phase.
	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_WAITING   = 2'd1,
		PH_REPEATING = 2'd2
	} phase_t;

	// Thresholds used by the key mask builder.
	typedef struct packed {
		logic [7:0]  trig_thresh;
		logic [14:0] stick_thresh;
	} thresh_t;

endpackage

### rtl/gamepad_keystroke_synthesizer.sv
// A request is accepted into the input register, and its result moves into
// the result register when the output is ready. Throughput: one request per
// cycle while out_stall is low; the key mask, both priority encoders and the
// 64-bit elapsed-time compare sit in the single stage between registers.
// Reset: arst_n clears the pipeline valids, reported keys, repeat phase, key
// and stamp at once, and loads the registers with their default values.
// ----------------------------------------------------------------------------
// gamepad_keystroke_synthesizer
// Typematic key event generator: turns gamepad polls into key down, key up
// and repeated key down events, at most one per poll.
// ----------------------------------------------------------------------------
module gamepad_keystroke_synthesizer #(
	parameter int KEY_COUNT = gks_pkg::KEY_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration
	input  logic                           cfg_we,
	input  logic [gks_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [gks_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Poll requests
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           pad_active,
	input  logic [15:0]                    button_bits,
	input  logic [7:0]                     left_trigger_level,
	input  logic [7:0]                     right_trigger_level,
	input  logic signed [15:0]             left_stick_x,
	input  logic signed [15:0]             left_stick_y,
	input  logic signed [15:0]             right_stick_x,
	input  logic signed [15:0]             right_stick_y,
	input  logic [63:0]                    time_ms,
	// Event results
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           event_status,
	output logic [5:0]                     key_index,
	output logic [1:0]                     event_kind
);

	// Configuration registers.
	logic [15:0]      repeat_delay_q;
	logic [15:0]      repeat_period_q;
	gks_pkg::thresh_t thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q          <= gks_pkg::RESET_REPEAT_DELAY;
			repeat_period_q         <= gks_pkg::RESET_REPEAT_PERIOD;
			thresh_q.trig_thresh    <= gks_pkg::RESET_TRIG_THRESH;
			thresh_q.stick_thresh   <= gks_pkg::RESET_STICK_THRESH;
		end else if (cfg_we) begin
			case (cfg_index)
				gks_pkg::REG_REPEAT_DELAY:  repeat_delay_q        <= cfg_data;
				gks_pkg::REG_REPEAT_PERIOD: repeat_period_q       <= cfg_data;
				gks_pkg::REG_TRIG_THRESH:   thresh_q.trig_thresh  <= cfg_data[7:0];
				gks_pkg::REG_STICK_THRESH:  thresh_q.stick_thresh <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Handshake control.
	logic valid_s1;
	logic out_valid_q;
	logic out_ready;
	logic adv_s1;
	logic in_fire;

	assign out_ready = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register.
	logic               pad_active_s1;
	logic [15:0]        button_bits_s1;
	logic [7:0]         left_trigger_s1;
	logic [7:0]         right_trigger_s1;
	logic signed [15:0] left_x_s1;
	logic signed [15:0] left_y_s1;
	logic signed [15:0] right_x_s1;
	logic signed [15:0] right_y_s1;
	logic [63:0]        time_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pad_active_s1    <= pad_active;
			button_bits_s1   <= button_bits;
			left_trigger_s1  <= left_trigger_level;
			right_trigger_s1 <= right_trigger_level;
			left_x_s1        <= left_stick_x;
			left_y_s1        <= left_stick_y;
			right_x_s1       <= right_stick_x;
			right_y_s1       <= right_stick_y;
			time_s1          <= time_ms;
		end
	end

	// Current key mask.
	logic [KEY_COUNT-1:0] current_keys;

	gks_key_mask #(
		.KEY_COUNT (KEY_COUNT)
	) u_key_mask (
		.thresh              (thresh_q),
		.pad_active          (pad_active_s1),
		.button_bits         (button_bits_s1),
		.left_trigger_level  (left_trigger_s1),
		.right_trigger_level (right_trigger_s1),
		.left_stick_x        (left_x_s1),
		.left_stick_y        (left_y_s1),
		.right_stick_x       (right_x_s1),
		.right_stick_y       (right_y_s1),
		.keys                (current_keys)
	);

	// Repeat state.
	logic [KEY_COUNT-1:0] reported_q;
	gks_pkg::phase_t      phase_q;
	logic [5:0]           repeat_key_q;
	logic [63:0]          repeat_stamp_q;

	// Elapsed time since the stamp; a borrow means time went backwards.
	logic [64:0] elapsed;
	logic        over_delay;
	logic        over_period;

	assign elapsed     = {1'b0, time_s1} - {1'b0, repeat_stamp_q};
	assign over_delay  = !elapsed[64] &&
		((elapsed[63:16] != '0) || (elapsed[15:0] > repeat_delay_q));
	assign over_period = !elapsed[64] &&
		((elapsed[63:16] != '0) || (elapsed[15:0] > repeat_period_q));

	// Changed keys, split into released and pressed, lowest of each isolated.
	logic [KEY_COUNT-1:0] valid_keys;
	logic [KEY_COUNT-1:0] changed;
	logic [KEY_COUNT-1:0] released;
	logic [KEY_COUNT-1:0] pressed;
	logic [KEY_COUNT-1:0] rel_onehot;
	logic [KEY_COUNT-1:0] press_onehot;
	logic                 rel_any;
	logic                 press_any;
	logic [5:0]           rel_idx;
	logic [5:0]           press_idx;

	always_comb begin
		valid_keys = '1;
		valid_keys[gks_pkg::GUIDE_BIT]   = 1'b0;
		valid_keys[gks_pkg::UNKNOWN_BIT] = 1'b0;
	end

	assign changed      = (current_keys ^ reported_q) & valid_keys;
	assign released     = changed & ~current_keys;
	assign pressed      = changed & current_keys;
	assign rel_onehot   = released & (~released + KEY_COUNT'(1));
	assign press_onehot = pressed & (~pressed + KEY_COUNT'(1));
	assign rel_any      = released != '0;
	assign press_any    = pressed != '0;

	// Priority encoders: the lowest set bit wins.
	always_comb begin
		rel_idx   = '0;
		press_idx = '0;
		for (int i = KEY_COUNT - 1; i >= 0; i--) begin
			if (released[i]) begin
				rel_idx = 6'(i);
			end
			if (pressed[i]) begin
				press_idx = 6'(i);
			end
		end
	end

	// Phase after the delay check, and whether a repeat is due.
	gks_pkg::phase_t phase_eff;
	logic            rep_fire;

	always_comb begin
		case (phase_q)
			gks_pkg::PH_WAITING:
				phase_eff = over_delay ? gks_pkg::PH_REPEATING : gks_pkg::PH_WAITING;
			gks_pkg::PH_REPEATING: phase_eff = gks_pkg::PH_REPEATING;
			default:               phase_eff = gks_pkg::PH_IDLE;
		endcase
	end

	assign rep_fire = (phase_eff == gks_pkg::PH_REPEATING) && over_period;

	// Next phase.
	gks_pkg::phase_t phase_d;

	always_comb begin
		if (rep_fire) begin
			phase_d = gks_pkg::PH_REPEATING;
		end else if (rel_any) begin
			phase_d = gks_pkg::PH_IDLE;
		end else if (press_any) begin
			phase_d = gks_pkg::PH_WAITING;
		end else begin
			phase_d = phase_eff;
		end
	end

	// Event and state outputs.
	logic                 status_d;
	logic [5:0]           key_d;
	logic [1:0]           kind_d;
	logic [KEY_COUNT-1:0] reported_d;
	logic                 load_key;
	logic                 load_stamp;

	always_comb begin
		status_d   = 1'b0;
		key_d      = '0;
		kind_d     = gks_pkg::KIND_DOWN;
		reported_d = reported_q;
		load_key   = 1'b0;
		load_stamp = 1'b0;
		if (rep_fire) begin
			status_d   = 1'b1;
			key_d      = repeat_key_q;
			kind_d     = gks_pkg::KIND_REPEAT;
			load_stamp = 1'b1;
		end else if (rel_any) begin
			status_d   = 1'b1;
			key_d      = rel_idx;
			kind_d     = gks_pkg::KIND_UP;
			reported_d = reported_q & ~rel_onehot;
		end else if (press_any) begin
			status_d   = 1'b1;
			key_d      = press_idx;
			kind_d     = gks_pkg::KIND_DOWN;
			reported_d = reported_q | press_onehot;
			load_key   = 1'b1;
			load_stamp = 1'b1;
		end
	end

	// State registers, advanced once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q     <= '0;
			phase_q        <= gks_pkg::PH_IDLE;
			repeat_key_q   <= '0;
			repeat_stamp_q <= '0;
		end else if (adv_s1) begin
			reported_q <= reported_d;
			phase_q    <= phase_d;
			if (load_key) begin
				repeat_key_q <= press_idx;
			end
			if (load_stamp) begin
				repeat_stamp_q <= time_s1;
			end
		end
	end

	// Result register.
	logic       event_status_q;
	logic [5:0] key_index_q;
	logic [1:0] event_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			event_status_q <= status_d;
			key_index_q    <= key_d;
			event_kind_q   <= kind_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_status = event_status_q;
	assign key_index    = key_index_q;
	assign event_kind   = event_kind_q;

	// Checks.
	`include "gamepad_keystroke_synthesizer_assert.svh"

	`GKS_ASSERT_SAME(a_no_event_zero, out_valid && !event_status, (key_index == '0) && (event_kind == gks_pkg::KIND_DOWN), "Empty result carries a key or kind")
	`GKS_ASSERT_SAME(a_hidden_keys, 1'b1, !reported_q[gks_pkg::GUIDE_BIT] && !reported_q[gks_pkg::UNKNOWN_BIT], "Guide or unknown key entered the reported mask")
	`GKS_ASSERT_SAME(a_repeat_needs_phase, adv_s1 && rep_fire, phase_q != gks_pkg::PH_IDLE, "Repeat fired from the idle phase")
	`GKS_ASSERT_NEXT(a_release_idles, adv_s1 && !rep_fire && rel_any, phase_q == gks_pkg::PH_IDLE, "Key up did not return the repeat machine to idle")
	`GKS_ASSERT_NEXT(a_repeat_result, adv_s1 && rep_fire, out_valid && event_status && (event_kind == gks_pkg::KIND_REPEAT), "Due repeat was not reported")

endmodule

### rtl/gks_key_mask.sv
// ----------------------------------------------------------------------------
// gks_key_mask
// Builds the key mask of one pad snapshot: buttons, triggers over their
// threshold and the eight directions of each stick.
// ----------------------------------------------------------------------------
module gks_key_mask #(
	parameter int KEY_COUNT = gks_pkg::KEY_COUNT_DEF
) (
	input  gks_pkg::thresh_t    thresh,
	input  logic                pad_active,
	input  logic [15:0]         button_bits,
	input  logic [7:0]          left_trigger_level,
	input  logic [7:0]          right_trigger_level,
	input  logic signed [15:0]  left_stick_x,
	input  logic signed [15:0]  left_stick_y,
	input  logic signed [15:0]  right_stick_x,
	input  logic signed [15:0]  right_stick_y,
	output logic [KEY_COUNT-1:0] keys
);

	// Eight direction bits of one stick; a diagonal replaces its two singles.
	function automatic logic [gks_pkg::STICK_DIRS-1:0] stick_dirs(
		input logic signed [15:0] x,
		input logic signed [15:0] y,
		input logic [14:0]        t
	);
		logic signed [15:0] pos;
		logic signed [15:0] neg;
		logic u, d, r, l;
		logic [gks_pkg::STICK_DIRS-1:0] f;
		pos = $signed({1'b0, t});
		neg = ~pos;
		u = y > pos;
		d = y < neg;
		r = x > pos;
		l = x < neg;
		f = '0;
		if (u && l) begin
			u = 1'b0; l = 1'b0; f[4] = 1'b1;
		end
		if (u && r) begin
			u = 1'b0; r = 1'b0; f[5] = 1'b1;
		end
		if (d && r) begin
			d = 1'b0; r = 1'b0; f[6] = 1'b1;
		end
		if (d && l) begin
			d = 1'b0; l = 1'b0; f[7] = 1'b1;
		end
		f[0] = u;
		f[1] = d;
		f[2] = r;
		f[3] = l;
		return f;
	endfunction

	logic [gks_pkg::MASK_MAX-1:0] full_keys;

	// Assemble the full mask; an inactive pad reads as all released.
	always_comb begin
		full_keys = '0;
		if (pad_active) begin
			full_keys[gks_pkg::BUTTON_COUNT-1:0] = button_bits;
			full_keys[gks_pkg::LEFT_TRIG_BIT]  = left_trigger_level > thresh.trig_thresh;
			full_keys[gks_pkg::RIGHT_TRIG_BIT] = right_trigger_level > thresh.trig_thresh;
			full_keys[gks_pkg::LEFT_STICK_LSB +: gks_pkg::STICK_DIRS] =
				stick_dirs(left_stick_x, left_stick_y, thresh.stick_thresh);
			full_keys[gks_pkg::RIGHT_STICK_LSB +: gks_pkg::STICK_DIRS] =
				stick_dirs(right_stick_x, right_stick_y, thresh.stick_thresh);
		end
	end

	assign keys = full_keys[KEY_COUNT-1:0];

endmodule
